// ===== hdl/lzrgb_pkg.sv =====
// Shared constants, types and helpers for the RGB555 LZ image compressor.
// Used by the controller, the datapath and the top level.
package lzrgb_pkg;

  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int MAX_DIST = 2047;
  localparam int DIST_W = 11;
  localparam int RUN_W = 4;
  localparam int WIN = 16;
  localparam int PEND_W = 5;
  localparam int TOK_W = 23;
  localparam int BYTES_W = 24;

  localparam logic [RUN_W-1:0] MAX_RUN = 4'd15;
  localparam logic [7:0] LIT_CODE = 8'h08;
  localparam logic [7:0] LIT_FLAG = 8'h20;
  localparam logic [TOK_W-1:0] TOK_MAX = {TOK_W{1'b1}};

  typedef struct packed {
    logic accept;
    logic start;
    logic load;
    logic search;
    logic build;
    logic deliver;
  } lzrgb_cmd_t;

  typedef struct packed {
    logic token_due;
    logic load_done;
    logic search_done;
  } lzrgb_sts_t;

  // floor(c * a / 255) for 8-bit c and a, exact over the whole range.
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] x;
    logic [16:0] s;
    begin
      x = {1'b0, 16'(c) * 16'(a)} + 17'd1;
      s = x + {8'd0, x[16:8]};
      premul = s[15:8];
    end
  endfunction

endpackage

// ===== hdl/lz_rgb555_image_compressor.sv =====
// A token is due once a 16-pixel look-ahead is complete or the final pixel is in.
// The window is loaded, then the single history read port feeds the search one
// distance per cycle, up to the reach of at most 2047, stopping on a full run.
// No pixel is accepted while tokens are made; one that causes no token goes from
// the check state back to idle. The final pixel flushes all tokens. Reset
// (synchronous, active low) clears the stream pointers and counts; history is left as is.
module lz_rgb555_image_compressor import lzrgb_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_alpha,
  input  logic               in_last_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_code_first_byte,
  output logic [7:0]         out_code_second_byte,
  output logic               out_has_data,
  output logic [7:0]         out_data_first_byte,
  output logic [7:0]         out_data_second_byte,
  output logic               out_last_token,
  output logic [BYTES_W-1:0] out_code_byte_count
);

  // The controller sequences each token: check whether a position is ready,
  // load a 16-pixel window, slide a candidate window back one distance per
  // cycle, then build and hand off the token beat.
  lzrgb_cmd_t cmd;
  lzrgb_sts_t sts;

  lzrgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzrgb_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_red               (in_red),
    .in_green             (in_green),
    .in_blue              (in_blue),
    .in_alpha             (in_alpha),
    .in_last_pixel        (in_last_pixel),
    .out_code_first_byte  (out_code_first_byte),
    .out_code_second_byte (out_code_second_byte),
    .out_has_data         (out_has_data),
    .out_data_first_byte  (out_data_first_byte),
    .out_data_second_byte (out_data_second_byte),
    .out_last_token       (out_last_token),
    .out_code_byte_count  (out_code_byte_count)
  );

endmodule

// ===== hdl/lzrgb_ctrl.sv =====
// Controller state machine of the compressor.
// Depends on lzrgb_pkg for the command and status structs.
module lzrgb_ctrl import lzrgb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lzrgb_sts_t sts,
  output lzrgb_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_LOAD   = 6'b000100,
    S_SEARCH = 6'b001000,
    S_BUILD  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.token_due ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        if (sts.load_done) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.search_done) state_nxt = S_BUILD;
      end
      S_BUILD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_CHECK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.accept  = (state_r == S_IDLE) && in_valid;
  assign cmd.start   = (state_r == S_CHECK) && sts.token_due;
  assign cmd.load    = (state_r == S_LOAD);
  assign cmd.search  = (state_r == S_SEARCH);
  assign cmd.build   = (state_r == S_BUILD);
  assign cmd.deliver = (state_r == S_OUT) && out_ready;

endmodule

// ===== hdl/lzrgb_dp.sv =====
// Datapath of the compressor: premultiply, pixel history memory, match window,
// search and token assembly. Depends on lzrgb_pkg; driven by lzrgb_ctrl through command and status structs.
module lzrgb_dp import lzrgb_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lzrgb_cmd_t         cmd,
  output lzrgb_sts_t         sts,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_alpha,
  input  logic               in_last_pixel,
  output logic [7:0]         out_code_first_byte,
  output logic [7:0]         out_code_second_byte,
  output logic               out_has_data,
  output logic [7:0]         out_data_first_byte,
  output logic [7:0]         out_data_second_byte,
  output logic               out_last_token,
  output logic [BYTES_W-1:0] out_code_byte_count
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

  logic [15:0] mem [HISTORY_DEPTH];
  logic [15:0] rdata_r;
  logic [AW-1:0] raddr;

  logic [AW-1:0] wr_ptr_r, enc_ptr_r, fwd_r, back_r;
  logic [PEND_W-1:0] pending_r;
  logic end_seen_r;
  logic [TOK_W-1:0] tok_r;
  logic [DIST_W-1:0] reach_r, dist_r, best_d_r;
  logic [RUN_W-1:0] best_c_r;
  logic [PEND_W-1:0] lc_r;
  logic [15:0] cur_r [WIN];
  logic [15:0] cand_r [WIN];
  logic [15:0] cand_eff [WIN];

  logic [7:0] pr, pg, pb;
  logic [15:0] packed_px;

  assign pr = premul(in_red, in_alpha);
  assign pg = premul(in_green, in_alpha);
  assign pb = premul(in_blue, in_alpha);
  assign packed_px = {pr[7:3], pg[7:5], pg[4:3], 1'b0, pb[7:3]};

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] p);
    inc_wrap = (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] p);
    dec_wrap = (p == '0) ? LAST_ADDR : p - AW'(1);
  endfunction

  // History memory: one write port for arriving pixels, one registered read.
  assign raddr = (cmd.load && lc_r < PEND_W'(WIN)) ? fwd_r : back_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) mem[wr_ptr_r] <= packed_px;
    rdata_r <= mem[raddr];
  end

  // Match length at the current distance.
  logic [WIN:0] eq_pre;
  logic [PEND_W-1:0] eq_cnt;
  logic [RUN_W-1:0] run_lim, run_len;
  logic dist_ok, at_limit;

  always_comb begin
    cand_eff[0] = rdata_r;
    for (int k = 1; k < WIN; k++) cand_eff[k] = cand_r[k-1];
    eq_pre[0] = 1'b1;
    for (int k = 0; k < WIN; k++) eq_pre[k+1] = eq_pre[k] && (cur_r[k] == cand_eff[k]);
    eq_cnt = '0;
    for (int k = 1; k <= WIN; k++) if (eq_pre[k]) eq_cnt = PEND_W'(k);
    if (end_seen_r && pending_r <= PEND_W'(WIN)) run_lim = RUN_W'(pending_r - PEND_W'(1));
    else run_lim = MAX_RUN;
    run_len = (eq_cnt > {1'b0, run_lim}) ? run_lim : eq_cnt[RUN_W-1:0];
  end

  assign dist_ok  = (dist_r <= reach_r);
  assign at_limit = (dist_r >= reach_r) || (dist_ok && run_len == MAX_RUN);

  // Token assembly.
  logic literal;
  logic [RUN_W-1:0] adv;
  logic [AW:0] enc_sum;
  logic [DIST_W:0] reach_sum;
  logic [TOK_W-1:0] tok_new;
  logic [PEND_W-1:0] pend_left;
  logic is_last;

  assign literal   = (best_c_r <= RUN_W'(1));
  assign adv       = literal ? RUN_W'(1) : best_c_r;
  assign enc_sum   = {1'b0, enc_ptr_r} + (AW+1)'(adv);
  assign reach_sum = {1'b0, reach_r} + (DIST_W+1)'(adv);
  assign tok_new   = (tok_r == TOK_MAX) ? tok_r : tok_r + TOK_W'(1);
  assign pend_left = pending_r - PEND_W'(adv);
  assign is_last   = end_seen_r && (pend_left == '0);

  assign sts.token_due   = (pending_r != '0) && (end_seen_r || pending_r >= PEND_W'(WIN));
  assign sts.load_done   = (lc_r == PEND_W'(WIN));
  assign sts.search_done = at_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      enc_ptr_r  <= '0;
      pending_r  <= '0;
      end_seen_r <= 1'b0;
      tok_r      <= '0;
      reach_r    <= '0;
    end else if (cmd.accept) begin
      wr_ptr_r   <= inc_wrap(wr_ptr_r);
      pending_r  <= pending_r + PEND_W'(1);
      end_seen_r <= end_seen_r | in_last_pixel;
    end else if (cmd.build) begin
      if (is_last) begin
        wr_ptr_r   <= '0;
        enc_ptr_r  <= '0;
        pending_r  <= '0;
        end_seen_r <= 1'b0;
        tok_r      <= '0;
        reach_r    <= '0;
      end else begin
        enc_ptr_r <= (enc_sum >= (AW+1)'(HISTORY_DEPTH))
                     ? AW'(enc_sum - (AW+1)'(HISTORY_DEPTH)) : enc_sum[AW-1:0];
        pending_r <= pend_left;
        tok_r     <= tok_new;
        reach_r   <= (reach_sum > (DIST_W+1)'(MAX_DIST)) ? DIST_W'(MAX_DIST)
                                                         : reach_sum[DIST_W-1:0];
      end
    end
  end

  // Window load and search registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fwd_r    <= enc_ptr_r;
      back_r   <= dec_wrap(enc_ptr_r);
      lc_r     <= '0;
      dist_r   <= DIST_W'(1);
      best_c_r <= '0;
      best_d_r <= '0;
    end else if (cmd.load) begin
      lc_r <= lc_r + PEND_W'(1);
      if (lc_r < PEND_W'(WIN)) fwd_r <= inc_wrap(fwd_r);
      else back_r <= dec_wrap(back_r);
      if (lc_r != '0) begin
        cur_r[lc_r[RUN_W-1:0] - RUN_W'(1)]  <= rdata_r;
        cand_r[lc_r[RUN_W-1:0] - RUN_W'(1)] <= rdata_r;
      end
    end else if (cmd.search) begin
      for (int k = 0; k < WIN; k++) cand_r[k] <= cand_eff[k];
      back_r <= dec_wrap(back_r);
      dist_r <= dist_r + DIST_W'(1);
      if (dist_ok && run_len > best_c_r) begin
        best_c_r <= run_len;
        best_d_r <= dist_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.build) begin
      out_code_first_byte  <= literal ? LIT_CODE : {best_c_r, 1'b0, best_d_r[10:8]};
      out_code_second_byte <= literal ? 8'h00 : best_d_r[7:0];
      out_has_data         <= literal;
      out_data_first_byte  <= literal ? (cur_r[0][7:0] | LIT_FLAG) : 8'h00;
      out_data_second_byte <= literal ? cur_r[0][15:8] : 8'h00;
      out_last_token       <= is_last;
      out_code_byte_count  <= !is_last ? '0 :
                              (tok_new == TOK_MAX) ? {BYTES_W{1'b1}} : {tok_new, 1'b0};
    end
  end

endmodule
